// ===== src/byte_mixing_key_schedule_unit_assert.svh =====
// assertion macros for the byte mixing key schedule unit
// used by byte_mixing_key_schedule_unit.sv, no other dependencies
`ifndef BYTE_MIXING_KEY_SCHEDULE_UNIT_ASSERT_SVH
`define BYTE_MIXING_KEY_SCHEDULE_UNIT_ASSERT_SVH

// same-cycle implication
`define BMKS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmks assertion failed: same cycle check");

// next-cycle implication
`define BMKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmks assertion failed: next cycle check");

`endif

// ===== src/bmks_pkg.sv =====
// shared types, constants and mixing functions of the byte mixing key schedule
// no dependencies
package bmks_pkg;

   localparam int RSP_DEPTH = 2;

   localparam logic [7:0] MAP_PRE_MIX  = 8'h1B;
   localparam logic [7:0] MAP_ALG_ZERO = 8'h06;
   localparam logic [7:0] MAP_DOUBLE   = 8'h22;

   localparam logic [2:0] ALG_CHAIN      = 3'd0;
   localparam logic [2:0] ALG_INC        = 3'd1;
   localparam logic [2:0] ALG_SWAP       = 3'd2;
   localparam logic [2:0] ALG_SWAP_INC   = 3'd3;
   localparam logic [2:0] ALG_SWAP_CHAIN = 3'd4;
   localparam logic [2:0] ALG_ROT        = 3'd5;
   localparam logic [2:0] ALG_ROT_INC    = 3'd6;
   localparam logic [2:0] ALG_ROT_CHAIN  = 3'd7;

   typedef logic [3:0][7:0] sched_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_PRE,
      STEP_MAIN,
      STEP_EXTRA
   } step_type;

   typedef struct packed {
      logic [15:0] seed;
      logic [15:0] nibble_select;
      logic [2:0]  alg_used;
      logic        last_of_run;
   } entry_type;

   // carry ripple from byte 3 down to byte 0
   function automatic sched_type carry_roll(sched_type s, logic [7:0] roll_init,
                                           logic carry_init);
      sched_type  r;
      logic [8:0] sum;
      logic [7:0] roll;
      logic       carry;
      r = s;
      roll = roll_init;
      carry = carry_init;
      for (int i = 3; i >= 0; i--) begin
         sum = {1'b0, roll} + {1'b0, s[i]} + {8'd0, carry};
         carry = sum[8];
         roll = sum[7:0];
         r[i] = roll;
      end
      return r;
   endfunction

   function automatic sched_type mix_chain(sched_type s, logic [7:0] map);
      logic [7:0] t;
      logic [8:0] sum;
      logic [8:0] sub;
      t = map ^ s[1];
      sum = {1'b0, t} + {1'b0, s[0]};
      sub = {1'b1, sum[7:0]} - {1'b0, s[2]} - {8'd0, ~sum[8]};
      return carry_roll(s, sub[7:0], sub[8]);
   endfunction

   function automatic sched_type mix_inc(sched_type s, logic [7:0] map);
      return carry_roll(s, map, 1'b1);
   endfunction

   function automatic sched_type mix_swap(sched_type s, logic [7:0] map);
      sched_type r;
      r[0] = s[3];
      r[1] = s[2];
      r[2] = s[1];
      r[3] = s[0] + map;
      return r;
   endfunction

   function automatic sched_type mix_rot(sched_type s, logic [7:0] map);
      sched_type  r;
      logic [7:0] t;
      t = {map[6:0], 1'b0} ^ 8'hFF;
      r[0] = t + s[0] - map;
      r[1] = s[3];
      r[2] = s[1];
      r[3] = s[2];
      return r;
   endfunction

   function automatic sched_type run_mix(logic [2:0] alg, logic [7:0] map, sched_type s);
      sched_type r;
      case (alg)
         ALG_CHAIN:      r = mix_chain(s, map);
         ALG_INC:        r = mix_inc(s, map);
         ALG_SWAP:       r = mix_swap(s, map);
         ALG_SWAP_INC:   r = mix_inc(mix_swap(s, map), map);
         ALG_SWAP_CHAIN: r = mix_chain(mix_swap(s, map), map);
         ALG_ROT:        r = mix_rot(s, map);
         ALG_ROT_INC:    r = mix_inc(mix_rot(s, map), map);
         default:        r = mix_chain(mix_rot(s, map), map);
      endcase
      return r;
   endfunction

endpackage

// ===== src/bmks_if.sv =====
// request and response channel interfaces of the byte mixing key schedule unit
// no dependencies
interface bmks_req_if;
   logic       valid;
   logic       ready;
   logic       restart;
   logic [7:0] map_number;

   modport source (output valid, output restart, output map_number, input ready);
   modport sink (input valid, input restart, input map_number, output ready);
endinterface

interface bmks_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] seed;
   logic [15:0] nibble_select;
   logic [2:0]  alg_used;
   logic        last_of_run;

   modport source (output valid, output seed, output nibble_select, output alg_used,
                   output last_of_run, input ready);
   modport sink (input valid, input seed, input nibble_select, input alg_used,
                 input last_of_run, output ready);
endinterface

// ===== src/byte_mixing_key_schedule_unit.sv =====
// top level of the byte mixing key schedule unit
// depends on bmks_pkg, bmks_if and byte_mixing_key_schedule_unit_assert.svh
//
// usage:
//   req_ch carries one word per map item (restart, map_number); rsp_ch carries one
//   word per schedule entry (seed, nibble_select, alg_used, last_of_run).
//   csr_write_data is taken into the key register on any edge with csr_write_enable
//   outside reset. each accepted word runs one mixing step per cycle, while the
//   response queue has room, over the four state bytes: one step for most maps,
//   two for 0x1B (pre-mix, then main) and two for 0x22 (main entry, then the extra
//   entry). the first entry of a word enters the response queue on the edge that
//   accepts it, or for 0x1B after its pre-mix step, and can be taken by the
//   receiver at the following edge. throughput is one word per cycle while the
//   queue has room; for maps 0x1B and 0x22 the next word waits for the second step.
//   results wait in a RSP_DEPTH-entry response queue; req_ch.ready drops while
//   the queue is full or a second step is pending, so a stalled receiver holds
//   back new words without loss.
//   reset (synchronous, active high) clears the key, the state bytes, the queue
//   and the pending step. no clearing pass is needed.
`include "byte_mixing_key_schedule_unit_assert.svh"

module byte_mixing_key_schedule_unit #(
   parameter int RSP_DEPTH = bmks_pkg::RSP_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   bmks_req_if.sink           req_ch,
   bmks_rsp_if.source         rsp_ch,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [31:0]             key_ff;
   bmks_pkg::sched_type     sched_ff, sched_in;
   bmks_pkg::step_type      pend_ff, pend_in;
   logic [7:0]              map_ff, map_in;
   bmks_pkg::entry_type     fifo_ff [RSP_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   bmks_pkg::step_type      step;
   bmks_pkg::sched_type     src;
   bmks_pkg::sched_type     mixed;
   bmks_pkg::entry_type     entry;
   logic [7:0]              map_cur;
   logic [2:0]              alg;
   logic                    full;
   logic                    accept;
   logic                    push;
   logic                    pop;

   function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(RSP_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full = (count_ff == CNT_W'(RSP_DEPTH));
   assign req_ch.ready = (pend_ff == bmks_pkg::STEP_NONE) && !full;
   assign accept = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (count_ff != '0);
   assign pop = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.seed          = fifo_ff[rd_ptr_ff].seed;
   assign rsp_ch.nibble_select = fifo_ff[rd_ptr_ff].nibble_select;
   assign rsp_ch.alg_used      = fifo_ff[rd_ptr_ff].alg_used;
   assign rsp_ch.last_of_run   = fifo_ff[rd_ptr_ff].last_of_run;

   always_comb begin
      step = bmks_pkg::STEP_NONE;
      map_cur = map_ff;
      src = sched_ff;
      if (accept) begin
         map_cur = req_ch.map_number;
         if (req_ch.restart) begin
            src[0] = key_ff[31:24];
            src[1] = key_ff[23:16];
            src[2] = key_ff[15:8];
            src[3] = key_ff[7:0];
         end
         step = (req_ch.map_number == bmks_pkg::MAP_PRE_MIX) ? bmks_pkg::STEP_PRE
                                                            : bmks_pkg::STEP_MAIN;
      end else if (pend_ff != bmks_pkg::STEP_NONE && !full) begin
         step = pend_ff;
      end

      case (step)
         bmks_pkg::STEP_PRE: begin
            alg = bmks_pkg::ALG_ROT_INC;
         end
         bmks_pkg::STEP_MAIN: begin
            alg = (map_cur == bmks_pkg::MAP_ALG_ZERO) ? bmks_pkg::ALG_CHAIN
                                                     : src[map_cur[5:4]][4:2];
         end
         bmks_pkg::STEP_EXTRA: begin
            alg = bmks_pkg::ALG_SWAP_CHAIN;
         end
         default: begin
            alg = bmks_pkg::ALG_CHAIN;
         end
      endcase

      mixed = bmks_pkg::run_mix(alg, map_cur, src);

      entry.seed = {mixed[0], mixed[1]};
      entry.nibble_select = {mixed[3], mixed[2]};
      entry.alg_used = alg;
      entry.last_of_run = !(step == bmks_pkg::STEP_MAIN && map_cur == bmks_pkg::MAP_DOUBLE);
      push = (step == bmks_pkg::STEP_MAIN) || (step == bmks_pkg::STEP_EXTRA);

      case (step)
         bmks_pkg::STEP_NONE: begin
            pend_in = pend_ff;
         end
         bmks_pkg::STEP_PRE: begin
            pend_in = bmks_pkg::STEP_MAIN;
         end
         bmks_pkg::STEP_MAIN: begin
            pend_in = (map_cur == bmks_pkg::MAP_DOUBLE) ? bmks_pkg::STEP_EXTRA
                                                       : bmks_pkg::STEP_NONE;
         end
         default: begin
            pend_in = bmks_pkg::STEP_NONE;
         end
      endcase

      sched_in = (step != bmks_pkg::STEP_NONE) ? mixed : sched_ff;
      map_in = map_cur;

      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         sched_ff <= '0;
         pend_ff <= bmks_pkg::STEP_NONE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            key_ff <= csr_write_data;
         end
         sched_ff <= sched_in;
         pend_ff <= pend_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      map_ff <= map_in;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry;
      end
   end

   `BMKS_ASSERT_NOW(a_no_push_when_full, clock, reset, push, count_ff != CNT_W'(RSP_DEPTH))
   `BMKS_ASSERT_NEXT(a_double_map_extra, clock, reset,
      accept && req_ch.map_number == bmks_pkg::MAP_DOUBLE, pend_ff == bmks_pkg::STEP_EXTRA)
   `BMKS_ASSERT_NEXT(a_pre_mix_then_main, clock, reset,
      accept && req_ch.map_number == bmks_pkg::MAP_PRE_MIX, pend_ff == bmks_pkg::STEP_MAIN)

endmodule
